FILE: rtl/xst_pkg.sv
// ----------------------------------------------------------------------------
// xst_pkg
// Shared types and constants for the xml stream tokenizer: parse states,
// tag kinds, byte roles, tag events and the beat structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package xst_pkg;

  // nesting depth limit and the width of the depth counter
  localparam int unsigned MaxDepth = 32;
  localparam int unsigned DepthW   = 6;

  // characters the tokenizer looks for
  localparam logic [7:0] ChLt    = 8'h3C;  // '<'
  localparam logic [7:0] ChGt    = 8'h3E;  // '>'
  localparam logic [7:0] ChQm    = 8'h3F;  // '?'
  localparam logic [7:0] ChSlash = 8'h2F;  // '/'
  localparam logic [7:0] ChEq    = 8'h3D;  // '='
  localparam logic [7:0] ChColon = 8'h3A;  // ':'
  localparam logic [7:0] ChUscr  = 8'h5F;  // '_'
  localparam logic [7:0] ChDash  = 8'h2D;  // '-'
  localparam logic [7:0] ChDot   = 8'h2E;  // '.'
  localparam logic [7:0] ChDquot = 8'h22;  // double quote
  localparam logic [7:0] ChSquot = 8'h27;  // single quote
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  typedef enum logic [3:0] {
    ST_BEGIN     = 4'd0,
    ST_BEGINTAG  = 4'd1,
    ST_PI        = 4'd2,
    ST_SLASHTAG  = 4'd3,
    ST_TAGNAME   = 4'd4,
    ST_AFTERNAME = 4'd5,
    ST_ATTRNAME  = 4'd6,
    ST_AFTERATTR = 4'd7,
    ST_AFTEREQ   = 4'd8,
    ST_ATTRVAL   = 4'd9,
    ST_CLOSE     = 4'd10,
    ST_TEXT      = 4'd11,
    ST_ERROR     = 4'd12
  } parse_state_e;

  typedef enum logic [1:0] {
    TK_NONE  = 2'd0,
    TK_START = 2'd1,
    TK_END   = 2'd2,
    TK_EMPTY = 2'd3
  } tag_kind_e;

  typedef enum logic [2:0] {
    ROLE_MARKUP    = 3'd0,
    ROLE_TAGNAME   = 3'd1,
    ROLE_ATTRNAME  = 3'd2,
    ROLE_ATTRVALUE = 3'd3,
    ROLE_TEXT      = 3'd4
  } char_role_e;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_NAME_END   = 3'd1,
    EV_START_DONE = 3'd2,
    EV_END_DONE   = 3'd3,
    EV_EMPTY_DONE = 3'd4
  } tag_event_e;

  // character classes of one byte
  typedef struct packed {
    logic space;
    logic start;
    logic name;
    logic lt;
    logic gt;
    logic qm;
    logic slash;
    logic eq;
    logic quote;
  } char_class_t;

  // tokenizer state carried from byte to byte
  typedef struct packed {
    parse_state_e      pstate;
    tag_kind_e         kind;
    logic [DepthW-1:0] depth;
  } tok_state_t;

  // per-byte findings of the step logic
  typedef struct packed {
    char_role_e role;
    tag_event_e ev;
    logic       attr_done;
    logic       stream_begin;
    logic       stanza_done;
    logic       stream_end;
  } step_res_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_of_chunk;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        char_role;
    logic [2:0]        tag_event;
    logic              attr_done;
    logic              stream_begin;
    logic              stanza_done;
    logic              stream_end;
    logic [DepthW-1:0] depth_out;
    logic              parse_error;
    logic              chunk_done;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: rtl/xml_stream_tokenizer_core.sv
// ----------------------------------------------------------------------------
// xml_stream_tokenizer_core
// Byte-wide XML tokenizer: one character in, one token report out.
//
// Input channel: in_valid_i / in_stall_o with in_beat_i (byte and chunk
// mark). A beat is taken at a rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with out_beat_o (byte role,
// tag event, attribute, stream and stanza flags, depth, error, chunk echo).
// Each input beat gives exactly one output beat, in order.
// A taken byte sits in an input register, then the classifier and the
// transition logic fill the result register and the parse state together.
// Throughput: one byte per clock while the receiver does not stall; the
// parse state is updated in the same cycle that moves a byte from the
// input register to the result register. When the receiver stalls, the
// result register holds its beat, the input register holds one more byte,
// and then in_stall_o rises.
// Reset: both registers are emptied, parse state returns to the begin
// state, tag kind to indefinite and depth to zero. A parse error is sticky
// until the next reset.
// ----------------------------------------------------------------------------
`default_nettype none

module xml_stream_tokenizer_core import xst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic        in_valid_q;
  in_beat_t    in_beat_q;
  logic        out_valid_q;
  logic        out_valid_d;
  out_beat_t   out_beat_q;
  out_beat_t   out_beat_d;
  tok_state_t  state_q;
  tok_state_t  state_d;
  tok_state_t  step_state;
  step_res_t   step_res;
  char_class_t cls;
  logic        out_free;
  logic        advance;
  logic        in_take;

  // handshake: result register frees when empty or drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_beat_q <= in_beat_i;
    end
  end

  // classify and step
  xst_char_class u_class (
    .char_i (in_beat_q.byte_in),
    .cls_o  (cls)
  );

  xst_step u_step (
    .state_i (state_q),
    .cls_i   (cls),
    .state_o (step_state),
    .res_o   (step_res)
  );

  // result beat assembly
  always_comb begin
    out_beat_d.char_role    = step_res.role;
    out_beat_d.tag_event    = step_res.ev;
    out_beat_d.attr_done    = step_res.attr_done;
    out_beat_d.stream_begin = step_res.stream_begin;
    out_beat_d.stanza_done  = step_res.stanza_done;
    out_beat_d.stream_end   = step_res.stream_end;
    out_beat_d.depth_out    = step_state.depth;
    out_beat_d.parse_error  = (step_state.pstate == ST_ERROR);
    out_beat_d.chunk_done   = in_beat_q.last_of_chunk;
  end

  assign state_d     = advance ? step_state : state_q;
  assign out_valid_d = advance ? 1'b1 : (out_valid_q && out_stall_i);

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{pstate: ST_BEGIN, kind: TK_NONE, depth: '0};
    end else begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

`ifndef SYNTH
  // depth never passes the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.depth <= DepthW'(MaxDepth))
    else $error("nesting depth above limit");

  // error state is sticky
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.pstate == ST_ERROR) |=> (state_q.pstate == ST_ERROR))
    else $error("left error state");

  // error beats carry no events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_beat_q.parse_error) |->
      ((out_beat_q.tag_event == EV_NONE) && !out_beat_q.attr_done &&
       !out_beat_q.stream_begin && !out_beat_q.stanza_done &&
       !out_beat_q.stream_end && (out_beat_q.char_role == ROLE_MARKUP)))
    else $error("event reported with parse error");

  // stream end leaves depth zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_beat_q.stream_end) |-> (out_beat_q.depth_out == '0))
    else $error("stream end with nonzero depth");

  // input register never overwritten while it holds a stalled byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_beat_q)))
    else $error("held input byte lost");
`endif

endmodule

`default_nettype wire

FILE: rtl/xst_char_class.sv
// ----------------------------------------------------------------------------
// xst_char_class
// Sorts one byte into the ASCII classes the tokenizer needs: white space,
// name start, name character and the single markup characters.
// ----------------------------------------------------------------------------
`default_nettype none

module xst_char_class import xst_pkg::*; (
  input  logic [7:0]  char_i,
  output char_class_t cls_o
);

  logic is_alpha;
  logic is_digit;

  // letter and digit ranges
  assign is_alpha = ((char_i >= 8'h61) && (char_i <= 8'h7A)) ||
                    ((char_i >= 8'h41) && (char_i <= 8'h5A));
  assign is_digit = (char_i >= 8'h30) && (char_i <= 8'h39);

  // class flags
  always_comb begin
    cls_o.space = (char_i == ChSpace) || (char_i == ChTab) ||
                  (char_i == ChCr) || (char_i == ChLf);
    cls_o.start = is_alpha || (char_i == ChColon) || (char_i == ChUscr);
    cls_o.name  = cls_o.start || is_digit || (char_i == ChDash) || (char_i == ChDot);
    cls_o.lt    = (char_i == ChLt);
    cls_o.gt    = (char_i == ChGt);
    cls_o.qm    = (char_i == ChQm);
    cls_o.slash = (char_i == ChSlash);
    cls_o.eq    = (char_i == ChEq);
    cls_o.quote = (char_i == ChDquot) || (char_i == ChSquot);
  end

endmodule

`default_nettype wire

FILE: rtl/xst_step.sv
// ----------------------------------------------------------------------------
// xst_step
// Transition logic of the tokenizer: from the current state and the class
// of one byte it works out the next state and the byte's role and events.
// ----------------------------------------------------------------------------
`default_nettype none

module xst_step import xst_pkg::*; (
  input  tok_state_t  state_i,
  input  char_class_t cls_i,
  output tok_state_t  state_o,
  output step_res_t   res_o
);

  localparam logic [DepthW-1:0] DepthMax  = DepthW'(MaxDepth);
  localparam logic [DepthW-1:0] DepthZero = '0;
  localparam logic [DepthW-1:0] DepthOne  = DepthW'(1);

  logic              push;
  logic              pop;
  logic [DepthW-1:0] d_mid;
  logic [DepthW-1:0] d_fin;

  // tag close on '>': push and pop of the nesting depth
  parse_state_e      c_pstate;
  logic [DepthW-1:0] c_depth;
  tag_event_e        c_ev;
  logic              c_sb;
  logic              c_sd;
  logic              c_se;

  assign push  = (state_i.kind == TK_START) || (state_i.kind == TK_EMPTY);
  assign pop   = (state_i.kind == TK_END) || (state_i.kind == TK_EMPTY);
  assign d_mid = push ? (state_i.depth + DepthOne) : state_i.depth;
  assign d_fin = d_mid - DepthOne;

  always_comb begin
    c_pstate = ST_TEXT;
    c_depth  = state_i.depth;
    c_ev     = EV_NONE;
    c_sb     = 1'b0;
    c_sd     = 1'b0;
    c_se     = 1'b0;
    if (state_i.kind != TK_NONE) begin
      if (push && (state_i.depth >= DepthMax)) begin
        c_pstate = ST_ERROR;
      end else if (pop && (d_mid == DepthZero)) begin
        c_pstate = ST_ERROR;
      end else begin
        c_depth = pop ? d_fin : d_mid;
        c_sb    = push && (state_i.depth == DepthZero);
        c_sd    = pop && (d_fin == DepthOne);
        c_se    = pop && (d_fin == DepthZero);
        unique case (state_i.kind)
          TK_START: c_ev = EV_START_DONE;
          TK_END:   c_ev = EV_END_DONE;
          default:  c_ev = EV_EMPTY_DONE;
        endcase
      end
    end
  end

  // next state and per-byte result
  always_comb begin
    state_o = state_i;
    res_o   = '{role: ROLE_MARKUP, ev: EV_NONE, default: 1'b0};
    unique case (state_i.pstate)
      ST_BEGIN: begin
        if (cls_i.lt) state_o.pstate = ST_BEGINTAG;
        else if (!cls_i.space) state_o.pstate = ST_ERROR;
      end
      ST_BEGINTAG: begin
        if (cls_i.start) begin
          state_o.pstate = ST_TAGNAME;
          state_o.kind   = TK_START;
          res_o.role     = ROLE_TAGNAME;
        end else if (cls_i.qm) begin
          state_o.pstate = ST_PI;
        end else if (cls_i.slash) begin
          state_o.pstate = ST_SLASHTAG;
          state_o.kind   = TK_END;
        end else begin
          state_o.pstate = ST_ERROR;
        end
      end
      ST_PI: begin
        if (cls_i.qm) state_o.pstate = ST_CLOSE;
      end
      ST_SLASHTAG: begin
        if (cls_i.start) begin
          state_o.pstate = ST_TAGNAME;
          res_o.role     = ROLE_TAGNAME;
        end else begin
          state_o.pstate = ST_ERROR;
        end
      end
      ST_TAGNAME: begin
        if (cls_i.name) begin
          res_o.role = ROLE_TAGNAME;
        end else if (cls_i.space) begin
          state_o.pstate = ST_AFTERNAME;
          res_o.ev       = EV_NAME_END;
        end else if (cls_i.slash) begin
          state_o.pstate = ST_CLOSE;
          state_o.kind   = TK_EMPTY;
          res_o.ev       = EV_NAME_END;
        end else if (cls_i.gt) begin
          state_o.pstate     = c_pstate;
          state_o.depth      = c_depth;
          res_o.ev           = c_ev;
          res_o.stream_begin = c_sb;
          res_o.stanza_done  = c_sd;
          res_o.stream_end   = c_se;
        end else begin
          state_o.pstate = ST_ERROR;
        end
      end
      ST_AFTERNAME: begin
        if (cls_i.start) begin
          state_o.pstate = ST_ATTRNAME;
          res_o.role     = ROLE_ATTRNAME;
        end else if (cls_i.slash) begin
          state_o.pstate = ST_CLOSE;
          state_o.kind   = TK_EMPTY;
        end else if (cls_i.gt) begin
          state_o.pstate     = c_pstate;
          state_o.depth      = c_depth;
          res_o.ev           = c_ev;
          res_o.stream_begin = c_sb;
          res_o.stanza_done  = c_sd;
          res_o.stream_end   = c_se;
        end else if (!cls_i.space) begin
          state_o.pstate = ST_ERROR;
        end
      end
      ST_ATTRNAME: begin
        if (cls_i.name) res_o.role = ROLE_ATTRNAME;
        else if (cls_i.eq) state_o.pstate = ST_AFTEREQ;
        else if (cls_i.space) state_o.pstate = ST_AFTERATTR;
        else state_o.pstate = ST_ERROR;
      end
      ST_AFTERATTR: begin
        if (cls_i.eq) state_o.pstate = ST_AFTEREQ;
        else if (!cls_i.space) state_o.pstate = ST_ERROR;
      end
      ST_AFTEREQ: begin
        if (cls_i.quote) state_o.pstate = ST_ATTRVAL;
        else if (!cls_i.space) state_o.pstate = ST_ERROR;
      end
      ST_ATTRVAL: begin
        if (cls_i.quote) begin
          state_o.pstate  = ST_AFTERNAME;
          res_o.attr_done = 1'b1;
        end else begin
          res_o.role = ROLE_ATTRVALUE;
        end
      end
      ST_CLOSE: begin
        if (cls_i.gt) begin
          state_o.pstate     = c_pstate;
          state_o.depth      = c_depth;
          res_o.ev           = c_ev;
          res_o.stream_begin = c_sb;
          res_o.stanza_done  = c_sd;
          res_o.stream_end   = c_se;
        end else begin
          state_o.pstate = ST_ERROR;
        end
      end
      ST_TEXT: begin
        if (cls_i.lt) begin
          state_o.pstate = ST_BEGINTAG;
          state_o.kind   = TK_NONE;
        end else if (state_i.depth != DepthZero) begin
          res_o.role = ROLE_TEXT;
        end
      end
      default: begin
        // sticky error, and any code outside the state list
        state_o.pstate = ST_ERROR;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: bench/xst_token_checker.sv
// ----------------------------------------------------------------------------
// xst_token_checker
// Watches both channels of the xml stream tokenizer. Every byte taken on the
// input side is run through a local tokenizer that keeps its own parse
// state, tag kind and nesting depth. The token report it yields is queued
// and compared field by field with the next report beat on the output side.
// ----------------------------------------------------------------------------

module xst_token_checker import xst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_beat_t    in_beat_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_beat_t   out_beat_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // local tokenizer state
  parse_state_e      pstate = ST_BEGIN;
  tag_kind_e         kind   = TK_NONE;
  logic [DepthW-1:0] depth  = '0;

  out_beat_t   expected_tokens[$];
  out_beat_t   want;
  int unsigned mismatches = 0;

  function automatic bit is_blank(logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChCr || c == ChLf;
  endfunction

  function automatic bit is_name_start(logic [7:0] c);
    return c == ChColon || c == ChUscr || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_name_rest(logic [7:0] c);
    return is_name_start(c) || c == ChDash || c == ChDot || (c >= "0" && c <= "9");
  endfunction

  // '>' ends the current tag: push and/or pop the depth, flag stream edges
  function automatic void finish_tag(inout out_beat_t res);
    tag_kind_e k;
    k = kind;
    pstate = ST_TEXT;
    if (k == TK_NONE) return;
    if (k == TK_START || k == TK_EMPTY) begin
      if (depth >= MaxDepth) begin
        pstate = ST_ERROR;
        return;
      end
      if (depth == 0) res.stream_begin = 1'b1;
      depth++;
    end
    if (k == TK_END || k == TK_EMPTY) begin
      if (depth == 0) begin
        pstate = ST_ERROR;
        return;
      end
      depth--;
      if (depth == 1) res.stanza_done = 1'b1;
      if (depth == 0) res.stream_end = 1'b1;
    end
    case (k)
      TK_START: res.tag_event = EV_START_DONE;
      TK_END:   res.tag_event = EV_END_DONE;
      default:  res.tag_event = EV_EMPTY_DONE;
    endcase
  endfunction

  // advance the local tokenizer by one byte and build its report
  function automatic out_beat_t tokenize_byte(in_beat_t beat);
    out_beat_t  res;
    logic [7:0] c;
    c   = beat.byte_in;
    res = '0;
    case (pstate)
      ST_BEGIN: begin
        if (c == ChLt) pstate = ST_BEGINTAG;
        else if (!is_blank(c)) pstate = ST_ERROR;
      end
      ST_BEGINTAG: begin
        if (is_name_start(c)) begin
          pstate        = ST_TAGNAME;
          kind          = TK_START;
          res.char_role = ROLE_TAGNAME;
        end else if (c == ChQm) begin
          pstate = ST_PI;
        end else if (c == ChSlash) begin
          kind   = TK_END;
          pstate = ST_SLASHTAG;
        end else begin
          pstate = ST_ERROR;
        end
      end
      ST_PI: begin
        if (c == ChQm) pstate = ST_CLOSE;
      end
      ST_SLASHTAG: begin
        if (is_name_start(c)) begin
          pstate        = ST_TAGNAME;
          res.char_role = ROLE_TAGNAME;
        end else begin
          pstate = ST_ERROR;
        end
      end
      ST_TAGNAME: begin
        if (is_name_rest(c)) begin
          res.char_role = ROLE_TAGNAME;
        end else if (is_blank(c)) begin
          pstate        = ST_AFTERNAME;
          res.tag_event = EV_NAME_END;
        end else if (c == ChSlash) begin
          pstate        = ST_CLOSE;
          kind          = TK_EMPTY;
          res.tag_event = EV_NAME_END;
        end else if (c == ChGt) begin
          finish_tag(res);
        end else begin
          pstate = ST_ERROR;
        end
      end
      ST_AFTERNAME: begin
        if (is_name_start(c)) begin
          pstate        = ST_ATTRNAME;
          res.char_role = ROLE_ATTRNAME;
        end else if (c == ChSlash) begin
          pstate = ST_CLOSE;
          kind   = TK_EMPTY;
        end else if (c == ChGt) begin
          finish_tag(res);
        end else if (!is_blank(c)) begin
          pstate = ST_ERROR;
        end
      end
      ST_ATTRNAME: begin
        if (is_name_rest(c)) res.char_role = ROLE_ATTRNAME;
        else if (c == ChEq) pstate = ST_AFTEREQ;
        else if (is_blank(c)) pstate = ST_AFTERATTR;
        else pstate = ST_ERROR;
      end
      ST_AFTERATTR: begin
        if (c == ChEq) pstate = ST_AFTEREQ;
        else if (!is_blank(c)) pstate = ST_ERROR;
      end
      ST_AFTEREQ: begin
        if (c == ChDquot || c == ChSquot) pstate = ST_ATTRVAL;
        else if (!is_blank(c)) pstate = ST_ERROR;
      end
      ST_ATTRVAL: begin
        if (c == ChDquot || c == ChSquot) begin
          pstate        = ST_AFTERNAME;
          res.attr_done = 1'b1;
        end else begin
          res.char_role = ROLE_ATTRVALUE;
        end
      end
      ST_CLOSE: begin
        if (c == ChGt) finish_tag(res);
        else pstate = ST_ERROR;
      end
      ST_TEXT: begin
        if (c == ChLt) begin
          pstate = ST_BEGINTAG;
          kind   = TK_NONE;
        end else if (depth != 0) begin
          res.char_role = ROLE_TEXT;
        end
      end
      // error is sticky: the byte is dropped
      default: pstate = ST_ERROR;
    endcase
    res.depth_out   = depth;
    res.parse_error = (pstate == ST_ERROR);
    res.chunk_done  = beat.last_of_chunk;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  // compare output beats first, then queue the report of the byte taken now
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pstate = ST_BEGIN;
      kind   = TK_NONE;
      depth  = '0;
      expected_tokens.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          $display("%0t: report beat with nothing expected, expected none, got %h",
                   $time, out_beat_i);
        end else begin
          want = expected_tokens.pop_front();
          check_field("char_role",    8'(want.char_role),    8'(out_beat_i.char_role));
          check_field("tag_event",    8'(want.tag_event),    8'(out_beat_i.tag_event));
          check_field("attr_done",    8'(want.attr_done),    8'(out_beat_i.attr_done));
          check_field("stream_begin", 8'(want.stream_begin), 8'(out_beat_i.stream_begin));
          check_field("stanza_done",  8'(want.stanza_done),  8'(out_beat_i.stanza_done));
          check_field("stream_end",   8'(want.stream_end),   8'(out_beat_i.stream_end));
          check_field("depth_out",    8'(want.depth_out),    8'(out_beat_i.depth_out));
          check_field("parse_error",  8'(want.parse_error),  8'(out_beat_i.parse_error));
          check_field("chunk_done",   8'(want.chunk_done),   8'(out_beat_i.chunk_done));
        end
      end
      if (in_valid_i && !in_stall_i) expected_tokens.push_back(tokenize_byte(in_beat_i));
      pending_o    <= expected_tokens.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: bench/tb_xml_stream_tokenizer_core.sv
// ----------------------------------------------------------------------------
// tb_xml_stream_tokenizer_core
// Feeds the tokenizer a byte stream: a short hand-written document, then
// random well-formed markup (nested tags, attributes, instructions, text,
// dives to the depth limit) and finally one randomly chosen error with
// noise behind it. Both sides pause at random; a checker does the compare.
// ----------------------------------------------------------------------------

module tb_xml_stream_tokenizer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import xst_pkg::*;

  localparam int unsigned RandomItems = 1500;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_beat   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_beat;
  int unsigned pending;
  int unsigned fail_count;

  in_beat_t byte_stream[$];
  int       gen_depth = 0;

  xml_stream_tokenizer_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  xst_token_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_beat_i   (out_beat),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // gap lengths: mostly none or short, a few long, with calm stretches
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_name_char(bit first);
    int unsigned r;
    r = $urandom_range(0, first ? 53 : 65);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r == 52) return ChColon;
    if (r == 53) return ChUscr;
    if (r == 54) return ChDash;
    if (r == 55) return ChDot;
    return 8'h30 + 8'(r - 56);
  endfunction

  function automatic logic [7:0] pick_byte_except(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
    return c;
  endfunction

  task automatic add_byte(input logic [7:0] ch);
    in_beat_t beat;
    beat.byte_in       = ch;
    beat.last_of_chunk = ($urandom_range(0, 7) == 0);
    byte_stream.push_back(beat);
  endtask

  task automatic add_spaces(input int unsigned lo, input int unsigned hi);
    int unsigned n;
    n = $urandom_range(lo, hi);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       add_byte(ChSpace);
        1:       add_byte(ChTab);
        2:       add_byte(ChCr);
        default: add_byte(ChLf);
      endcase
    end
  endtask

  task automatic add_name();
    int unsigned n;
    add_byte(pick_name_char(1'b1));
    n = $urandom_range(0, 4);
    repeat (n) add_byte(pick_name_char(1'b0));
  endtask

  // name = quoted value, either quote at either end
  task automatic add_attr();
    int unsigned n;
    add_name();
    add_spaces(0, 1);
    add_byte(ChEq);
    add_spaces(0, 1);
    add_byte($urandom_range(0, 1) ? ChDquot : ChSquot);
    n = $urandom_range(0, 5);
    repeat (n) add_byte(pick_byte_except(ChDquot, ChSquot));
    add_byte($urandom_range(0, 1) ? ChDquot : ChSquot);
  endtask

  task automatic add_open_tag(input bit empty);
    int unsigned n;
    add_byte(ChLt);
    add_name();
    n = $urandom_range(0, 2);
    for (int unsigned k = 0; k < n; k++) begin
      add_spaces(k == 0 ? 1 : 0, 2);
      add_attr();
    end
    if ($urandom_range(0, 3) == 0) add_spaces(1, 2);
    if (empty) begin
      add_byte(ChSlash);
      add_byte(ChGt);
    end else begin
      add_byte(ChGt);
      gen_depth++;
    end
  endtask

  // end tag; now and then with an attribute or turned into an empty tag
  task automatic add_close_tag();
    int unsigned r;
    add_byte(ChLt);
    add_byte(ChSlash);
    add_name();
    r = $urandom_range(0, 15);
    if (r == 0) begin
      add_spaces(1, 1);
      add_attr();
    end
    if (r == 1 && gen_depth < MaxDepth) begin
      add_byte(ChSlash);
      add_byte(ChGt);
    end else begin
      add_spaces(0, 1);
      add_byte(ChGt);
      gen_depth--;
    end
  endtask

  task automatic add_instruction();
    int unsigned n;
    add_byte(ChLt);
    add_byte(ChQm);
    n = $urandom_range(0, 4);
    repeat (n) add_byte(pick_byte_except(ChQm, ChQm));
    add_byte(ChQm);
    add_byte(ChGt);
  endtask

  task automatic add_text();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) add_byte(pick_byte_except(ChLt, ChLt));
  endtask

  task automatic add_nesting_to_limit();
    while (gen_depth < MaxDepth) begin
      add_open_tag(1'b0);
      if ($urandom_range(0, 2) == 0) add_text();
    end
  endtask

  // receiver pacing
  initial begin : sink_pacing
    int unsigned stall_left;
    int unsigned calm;
    stall_left = 0;
    calm       = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(calm);
      end
    end
  end

  // no beat moving on either side for too long ends the run
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned calm;
    int unsigned gap;
    int unsigned r;
    int unsigned stop_len;
    int unsigned n;

    // hand-written document: spaces of every kind before the root, an
    // instruction with a high byte, mixed quotes, a zero byte as text, an
    // empty tag closing the name with '/', an end tag closed right after
    // its name, then a byte at depth zero that is ignored
    add_byte(ChTab);
    add_byte(ChCr);
    add_byte(ChLf);
    add_byte(ChSpace);
    add_byte(ChLt);
    add_byte(ChQm);
    add_byte(8'hFF);
    add_byte(ChQm);
    add_byte(ChGt);
    add_byte(ChLt);
    add_byte("A");
    add_byte(ChColon);
    add_byte(ChSpace);
    add_byte("b");
    add_byte(ChEq);
    add_byte(ChSquot);
    add_byte(8'h80);
    add_byte(ChDquot);
    add_byte(ChGt);
    add_byte(8'h00);
    add_byte(ChLt);
    add_byte("c");
    add_byte(ChSlash);
    add_byte(ChGt);
    add_byte(ChLt);
    add_byte(ChSlash);
    add_byte("z");
    add_byte(ChGt);
    add_byte(8'h7F);
    gen_depth = 0;

    // random well-formed markup, starting with one dive to the limit
    stop_len = byte_stream.size() + RandomItems;
    add_nesting_to_limit();
    while (byte_stream.size() < stop_len) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 299) == 0) begin
        add_nesting_to_limit();
      end else if (gen_depth == 0) begin
        if (r < 55) add_open_tag(1'b0);
        else if (r < 70) add_open_tag(1'b1);
        else if (r < 80) add_instruction();
        else add_text();
      end else if (r < (gen_depth > 6 ? 12 : 30)) begin
        if (gen_depth < MaxDepth) add_open_tag(1'b0);
        else add_close_tag();
      end else if (r < 65) begin
        add_close_tag();
      end else if (r < 72 && gen_depth < MaxDepth) begin
        add_open_tag(1'b1);
      end else if (r < 93) begin
        add_text();
      end else begin
        add_instruction();
      end
    end

    // one error to finish: overflow by start or empty tag, underflow, or a
    // byte of no class where a name must start; then noise
    case ($urandom_range(0, 3))
      0: begin
        add_nesting_to_limit();
        add_open_tag(1'b0);
      end
      1: begin
        add_nesting_to_limit();
        add_open_tag(1'b1);
      end
      2: begin
        while (gen_depth > 0) add_close_tag();
        add_byte(ChLt);
        add_byte(ChSlash);
        add_byte("q");
        add_byte(ChGt);
      end
      default: begin
        add_byte(ChLt);
        add_byte(8'($urandom_range(128, 255)));
      end
    endcase
    n = $urandom_range(16, 32);
    repeat (n) add_byte(8'($urandom_range(0, 255)));

    // reset
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // send every byte; twice hold off until all reports are back
    calm = 0;
    for (int unsigned i = 0; i < byte_stream.size(); i++) begin
      gap = pick_gap(calm);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_beat  <= byte_stream[i];
      do @(posedge clk); while (in_stall);
      if (i == byte_stream.size() / 3 || i == 2 * byte_stream.size() / 3) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/xst_pkg.sv
rtl/xst_char_class.sv
rtl/xst_step.sv
rtl/xml_stream_tokenizer_core.sv
bench/xst_token_checker.sv
bench/tb_xml_stream_tokenizer_core.sv
